// File: hw/rtl/best_fit_buffer_pool_defines.svh
// Assertion macros for the buffer pool RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef BEST_FIT_BUFFER_POOL_DEFINES_SVH
`define BEST_FIT_BUFFER_POOL_DEFINES_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante
`define BFBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bfbp assertion failed");

// Check that cons holds in the cycle after ante
`define BFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bfbp assertion failed");

`else

`define BFBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BFBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/bfbp_pkg.sv
`default_nettype none

package bfbp_pkg;

    // Pool geometry
    localparam int MAX_ENTRIES_DEF = 128;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 32;
    localparam int HANDLE_W = 7;
    localparam int LOG_W    = 5;
    localparam int STATUS_W = 3;

    // Reset value of the minimum block size register
    localparam logic [LOG_W-1:0] MIN_BLOCK_LOG2_RST = 5'd12;

    // Largest request accepted, 2^31 bytes
    localparam logic [SIZE_W-1:0] MAX_REQ_SIZE = 32'h8000_0000;

    // Largest log2 of a block size
    localparam logic [LOG_W-1:0] MAX_LOG2 = 5'd31;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_REUSED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

    // One stored pool entry
    typedef struct packed {
        logic             busy;
        logic [LOG_W-1:0] size_log2;
    } t_entry;

    // Single-port access to the entry memory
    typedef struct packed {
        logic   en;
        logic   we;
        t_entry wdata;
    } t_ram_ctl;

endpackage

`default_nettype wire

// File: hw/rtl/bfbp_entry_ram.sv
`default_nettype none

// Single-port entry memory, registered read
module bfbp_entry_ram #(
    parameter int DEPTH  = bfbp_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire bfbp_pkg::t_ram_ctl   i_ctl,
    input  wire logic [ADDR_W-1:0]    i_addr,
    output bfbp_pkg::t_entry          o_rdata
);

    bfbp_pkg::t_entry r_mem [DEPTH];
    bfbp_pkg::t_entry r_rdata;

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                r_mem[i_addr] <= i_ctl.wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/best_fit_buffer_pool.sv
// Sequence: release reads its entry and then frees it; clear and rejected commands go straight to
//   the output; acquire finds need (ceil log2 of the request, one bit per cycle), scans, decides.
// Throughput: one command at a time; the scan of an acquire reads the single-port
//   entry memory one entry per cycle.
// Reset: synchronous, active low; empties the pool and sets min_block_log2 to 12.
//   No clearing pass: the entry count bounds every read of the memory.
`default_nettype none

`include "best_fit_buffer_pool_defines.svh"

module best_fit_buffer_pool #(
    parameter int MAX_ENTRIES = bfbp_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [bfbp_pkg::LOG_W-1:0]      i_cfg_data,
    // Command channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [bfbp_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [bfbp_pkg::SIZE_W-1:0]     i_req_size,
    input  wire logic [bfbp_pkg::HANDLE_W-1:0]   i_handle_in,
    // Result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [bfbp_pkg::HANDLE_W-1:0]        o_handle,
    output logic [bfbp_pkg::LOG_W-1:0]           o_block_size_log2,
    output logic [bfbp_pkg::STATUS_W-1:0]        o_status
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int XW    = (CNT_W > bfbp_pkg::HANDLE_W) ? CNT_W : bfbp_pkg::HANDLE_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOG    = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_REL    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state                             r_state, n_state;
    logic [bfbp_pkg::LOG_W-1:0]         r_min_log2;
    logic [CNT_W-1:0]                   r_count;
    logic [bfbp_pkg::SIZE_W-1:0]        r_req;
    logic [bfbp_pkg::LOG_W-1:0]         r_lg;
    logic [CNT_W-1:0]                   r_addr;
    logic                               r_pend;
    logic [IDX_W-1:0]                   r_eidx;
    logic                               r_found;
    logic [IDX_W-1:0]                   r_best;
    logic [bfbp_pkg::LOG_W-1:0]         r_best_lg;
    logic [bfbp_pkg::HANDLE_W-1:0]      r_res_handle;
    logic [bfbp_pkg::LOG_W-1:0]         r_res_lg;
    logic [bfbp_pkg::STATUS_W-1:0]      r_res_status;
    logic                               r_o_valid;
    logic [bfbp_pkg::HANDLE_W-1:0]      r_o_handle;
    logic [bfbp_pkg::LOG_W-1:0]         r_o_lg;
    logic [bfbp_pkg::STATUS_W-1:0]      r_o_status;

    logic                               in_acc;
    logic [XW-1:0]                      hin_x;
    logic [XW-1:0]                      cnt_x;
    logic [XW-1:0]                      best_x;
    logic [XW-1:0]                      new_x;
    logic                               hin_known;
    logic                               log_more;
    logic                               issue;
    logic                               fits;
    logic [bfbp_pkg::LOG_W-1:0]         need_new;
    logic                               out_free;
    bfbp_pkg::t_ram_ctl                 ram_ctl;
    logic [IDX_W-1:0]                   ram_addr;
    bfbp_pkg::t_entry                   ram_rdata;

    // Handshake and helper terms
    assign in_acc    = i_valid && o_ready;
    assign hin_x     = XW'(i_handle_in);
    assign cnt_x     = XW'(r_count);
    assign best_x    = XW'(r_best);
    assign new_x     = XW'(r_count);
    assign hin_known = hin_x < cnt_x;
    assign log_more  = (r_lg < bfbp_pkg::MAX_LOG2) &&
                       ((33'd1 << r_lg) < {1'b0, r_req});
    assign issue     = r_addr < r_count;
    assign fits      = !ram_rdata.busy && (ram_rdata.size_log2 >= r_lg) &&
                       (!r_found || (ram_rdata.size_log2 < r_best_lg));
    assign need_new  = (r_lg < r_min_log2) ? r_min_log2 : r_lg;
    assign out_free  = !r_o_valid || i_ready;

    // Entry memory
    bfbp_entry_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_ctl   (ram_ctl),
        .i_addr  (ram_addr),
        .o_rdata (ram_rdata)
    );

    // Drive the memory port; the sequencer never overlaps accesses
    always_comb begin
        ram_ctl  = '0;
        ram_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_cmd == bfbp_pkg::CMD_RELEASE) && hin_known) begin
                    ram_ctl.en = 1'b1;
                    ram_addr   = hin_x[IDX_W-1:0];
                end
            end
            S_SCAN: begin
                ram_ctl.en = issue;
                ram_addr   = r_addr[IDX_W-1:0];
            end
            S_DECIDE: begin
                if (r_found) begin
                    ram_ctl.en              = 1'b1;
                    ram_ctl.we              = 1'b1;
                    ram_ctl.wdata.busy      = 1'b1;
                    ram_ctl.wdata.size_log2 = r_best_lg;
                    ram_addr                = r_best;
                end else if (r_count != CNT_MAX) begin
                    ram_ctl.en              = 1'b1;
                    ram_ctl.we              = 1'b1;
                    ram_ctl.wdata.busy      = 1'b1;
                    ram_ctl.wdata.size_log2 = need_new;
                    ram_addr                = r_count[IDX_W-1:0];
                end
            end
            S_REL: begin
                ram_ctl.en              = 1'b1;
                ram_ctl.we              = 1'b1;
                ram_ctl.wdata.busy      = 1'b0;
                ram_ctl.wdata.size_log2 = ram_rdata.size_log2;
                ram_addr                = r_eidx;
            end
            S_LOG, S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Sequence the commands
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        bfbp_pkg::CMD_ACQUIRE: begin
                            n_state = (i_req_size > bfbp_pkg::MAX_REQ_SIZE) ? S_OUT : S_LOG;
                        end
                        bfbp_pkg::CMD_RELEASE: n_state = hin_known ? S_REL : S_OUT;
                        bfbp_pkg::CMD_CLEAR:   n_state = S_OUT;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_LOG:    n_state = log_more ? S_LOG : S_SCAN;
            S_SCAN:   n_state = (!issue && !r_pend) ? S_DECIDE : S_SCAN;
            S_DECIDE: n_state = S_OUT;
            S_REL:    n_state = S_OUT;
            S_OUT:    n_state = out_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_min_log2 <= bfbp_pkg::MIN_BLOCK_LOG2_RST;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_min_log2 <= i_cfg_data;
            end
            // Track the entry count
            if (r_state == S_IDLE && in_acc && i_cmd == bfbp_pkg::CMD_CLEAR) begin
                r_count <= '0;
            end else if (r_state == S_DECIDE && !r_found && r_count != CNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
            // Scan pipeline
            if (r_state == S_LOG) begin
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_pend <= issue;
                if (r_pend && fits) begin
                    r_found <= 1'b1;
                end
            end
            // Hand the result to the output register
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req    <= i_req_size;
                r_lg     <= '0;
                r_eidx   <= hin_x[IDX_W-1:0];
                r_res_lg <= '0;
                if (i_cmd == bfbp_pkg::CMD_RELEASE) begin
                    r_res_handle <= i_handle_in;
                    r_res_status <= bfbp_pkg::ST_UNKNOWN;
                end else if (i_cmd == bfbp_pkg::CMD_CLEAR) begin
                    r_res_handle <= '0;
                    r_res_status <= bfbp_pkg::ST_CLEARED;
                end else begin
                    r_res_handle <= '0;
                    r_res_status <= bfbp_pkg::ST_TOO_LARGE;
                end
            end
            S_LOG: begin
                r_addr <= '0;
                if (log_more) begin
                    r_lg <= r_lg + 1'b1;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    r_addr <= r_addr + 1'b1;
                    r_eidx <= r_addr[IDX_W-1:0];
                end
                if (r_pend && fits) begin
                    r_best    <= r_eidx;
                    r_best_lg <= ram_rdata.size_log2;
                end
            end
            S_DECIDE: begin
                if (r_found) begin
                    r_res_handle <= best_x[bfbp_pkg::HANDLE_W-1:0];
                    r_res_lg     <= r_best_lg;
                    r_res_status <= bfbp_pkg::ST_REUSED;
                end else if (r_count != CNT_MAX) begin
                    r_res_handle <= new_x[bfbp_pkg::HANDLE_W-1:0];
                    r_res_lg     <= need_new;
                    r_res_status <= bfbp_pkg::ST_NEW;
                end else begin
                    r_res_handle <= '0;
                    r_res_lg     <= '0;
                    r_res_status <= bfbp_pkg::ST_POOL_FULL;
                end
            end
            S_REL: begin
                r_res_lg     <= ram_rdata.size_log2;
                r_res_status <= bfbp_pkg::ST_RELEASED;
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_handle <= r_res_handle;
                    r_o_lg     <= r_res_lg;
                    r_o_status <= r_res_status;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready       = 1'b1;
    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_handle          = r_o_handle;
    assign o_block_size_log2 = r_o_lg;
    assign o_status          = r_o_status;

    // Assertions
    `BFBP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX)
    `BFBP_ASSERT_NOW(a_best_in_pool, i_clk, i_rst_n, (r_state == S_DECIDE) && r_found, CNT_W'(r_best) < r_count)
    `BFBP_ASSERT_NOW(a_rise_from_out, i_clk, i_rst_n, $rose(o_valid), $past(r_state) == S_OUT)
    `BFBP_ASSERT_NEXT(a_release_reads, i_clk, i_rst_n, in_acc && (i_cmd == bfbp_pkg::CMD_RELEASE) && hin_known, r_state == S_REL)

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;

    // Field widths of the pool
    localparam int CMD_W    = bfbp_pkg::CMD_W;
    localparam int SIZE_W   = bfbp_pkg::SIZE_W;
    localparam int HANDLE_W = bfbp_pkg::HANDLE_W;
    localparam int LOG_W    = bfbp_pkg::LOG_W;
    localparam int STATUS_W = bfbp_pkg::STATUS_W;

    // Command code with no meaning to the pool; it yields no reply
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_SLOTS     = bfbp_pkg::MAX_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam int N_DIR         = 21;
    localparam int N_RAND        = 240;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LOG_W-1:0]    size_lg;
        logic [STATUS_W-1:0] status;
    } t_reply;

    // One command transaction; a fixed row carries its reply typed in by hand
    typedef struct packed {
        logic [CMD_W-1:0]    op;
        logic [SIZE_W-1:0]   req_size;
        logic [HANDLE_W-1:0] handle_in;
        logic                fixed;
        t_reply              reply;
    } t_request;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LOG_W-1:0]    i_cfg_data  = bfbp_pkg::MIN_BLOCK_LOG2_RST;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic [CMD_W-1:0]    i_cmd       = bfbp_pkg::CMD_ACQUIRE;
    logic [SIZE_W-1:0]   i_req_size  = '0;
    logic [HANDLE_W-1:0] i_handle_in = '0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [HANDLE_W-1:0] o_handle;
    logic [LOG_W-1:0]    o_block_size_log2;
    logic [STATUS_W-1:0] o_status;

    // Shadow copy of the pool
    logic [LOG_W-1:0] pool_lg [MAX_SLOTS];
    logic             pool_busy [MAX_SLOTS] = '{default: 1'b0};
    int unsigned      pool_count   = 0;
    logic [LOG_W-1:0] min_block_lg = bfbp_pkg::MIN_BLOCK_LOG2_RST;

    t_reply      pending_replies [$];
    int unsigned n_errors      = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;

    best_fit_buffer_pool #(
        .MAX_ENTRIES(MAX_SLOTS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_req_size        (i_req_size),
        .i_handle_in       (i_handle_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_handle          (o_handle),
        .o_block_size_log2 (o_block_size_log2),
        .o_status          (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the pool hangs
    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

    // Apply one command to the shadow pool; return 1 when it yields a reply
    function automatic logic pool_predict(input t_request rq, output t_reply rp);
        logic [LOG_W-1:0] need;
        logic [LOG_W-1:0] best_lg;
        int unsigned      best;
        int unsigned      i;
        logic             found;
        rp      = '0;
        need    = '0;
        best_lg = '0;
        best    = 0;
        found   = 1'b0;
        case (rq.op)
            bfbp_pkg::CMD_ACQUIRE: begin
                if (rq.req_size > bfbp_pkg::MAX_REQ_SIZE) begin
                    rp.status = bfbp_pkg::ST_TOO_LARGE;
                    return 1'b1;
                end
                // Round the request up to a power of two; zero counts as one
                while (need < bfbp_pkg::MAX_LOG2 &&
                        (64'd1 << need) < 64'(rq.req_size))
                    need++;
                // Smallest free entry that fits, lowest index on a tie
                for (i = 0; i < pool_count; i++) begin
                    if (!pool_busy[i] && pool_lg[i] >= need &&
                            (!found || pool_lg[i] < best_lg)) begin
                        found   = 1'b1;
                        best    = i;
                        best_lg = pool_lg[i];
                    end
                end
                if (found) begin
                    pool_busy[best] = 1'b1;
                    rp.handle  = HANDLE_W'(best);
                    rp.size_lg = best_lg;
                    rp.status  = bfbp_pkg::ST_REUSED;
                end else if (pool_count >= MAX_SLOTS) begin
                    rp.status = bfbp_pkg::ST_POOL_FULL;
                end else begin
                    if (need < min_block_lg)
                        need = min_block_lg;
                    pool_lg[pool_count]   = need;
                    pool_busy[pool_count] = 1'b1;
                    rp.handle  = HANDLE_W'(pool_count);
                    rp.size_lg = need;
                    rp.status  = bfbp_pkg::ST_NEW;
                    pool_count++;
                end
            end
            bfbp_pkg::CMD_RELEASE: begin
                rp.handle = rq.handle_in;
                if (rq.handle_in >= pool_count) begin
                    rp.status = bfbp_pkg::ST_UNKNOWN;
                end else begin
                    pool_busy[rq.handle_in] = 1'b0;
                    rp.size_lg = pool_lg[rq.handle_in];
                    rp.status  = bfbp_pkg::ST_RELEASED;
                end
            end
            bfbp_pkg::CMD_CLEAR: begin
                for (i = 0; i < MAX_SLOTS; i++)
                    pool_busy[i] = 1'b0;
                pool_count = 0;
                rp.status  = bfbp_pkg::ST_CLEARED;
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Size spread over the power-of-two classes, mostly the small ones
    function automatic logic [SIZE_W-1:0] random_size();
        int unsigned       lg;
        logic [SIZE_W-1:0] half;
        lg = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(14);
        if (lg == 0)
            return SIZE_W'($urandom_range(1));
        half = 32'd1 << (lg - 1);
        return half + $urandom_range(half, 1);
    endfunction

    function automatic t_request random_request();
        t_request    rq;
        int unsigned pick;
        rq           = '0;
        rq.req_size  = $urandom;
        rq.handle_in = HANDLE_W'($urandom);
        pick         = $urandom_range(99);
        if (pick < 1) begin
            rq.op = bfbp_pkg::CMD_CLEAR;
        end else if (pick < 3) begin
            rq.op = CMD_UNUSED;
        end else if (pick < 6) begin
            rq.op       = bfbp_pkg::CMD_ACQUIRE;
            rq.req_size = $urandom_range(32'hFFFF_FFFF, 32'h8000_0001);
        end else if (pick < 55) begin
            rq.op       = bfbp_pkg::CMD_ACQUIRE;
            rq.req_size = random_size();
        end else begin
            rq.op = bfbp_pkg::CMD_RELEASE;
            // Mostly live handles, now and then any handle at all
            if (pick < 93 && pool_count != 0)
                rq.handle_in = HANDLE_W'($urandom_range(pool_count - 1));
        end
        return rq;
    endfunction

    // Send one command transaction and note the reply it should bring
    task automatic issue(input t_request rq);
        t_reply guess;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= rq.op;
        i_req_size  <= rq.req_size;
        i_handle_in <= rq.handle_in;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        if (pool_predict(rq, guess)) begin
            if (rq.fixed)
                guess = rq.reply;
            pending_replies = {pending_replies, guess};
        end
    endtask

    // Hold off new commands until every reply is back
    task automatic drain_replies();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_replies.size() != 0);
    endtask

    task automatic write_min_block(input logic [LOG_W-1:0] lg);
        drain_replies();
        // Let an unanswered command finish before touching the register
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lg;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        min_block_lg = lg;
    endtask

    task automatic run_random(input int unsigned n_items);
        t_request    rq;
        int unsigned done;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(49) == 0)
                drain_replies();
            rq = random_request();
            issue(rq);
            if (rq.op != CMD_UNUSED)
                done++;
        end
    endtask

    // Random back-pressure on the reply channel
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compare each reply transaction with the oldest one pending
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                n_errors++;
                $display({"%0t: unexpected reply, expected none, ",
                          "got handle %0d size_lg %0d status %0d"},
                         $time, o_handle, o_block_size_log2, o_status);
            end else begin
                want = pending_replies.pop_front();
                if (o_handle !== want.handle) begin
                    n_errors++;
                    $display("%0t: handle mismatch, expected %0d, got %0d",
                             $time, want.handle, o_handle);
                end
                if (o_block_size_log2 !== want.size_lg) begin
                    n_errors++;
                    $display("%0t: block_size_log2 mismatch, expected %0d, got %0d",
                             $time, want.size_lg, o_block_size_log2);
                end
                if (o_status !== want.status) begin
                    n_errors++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                end
            end
        end
    end

    initial begin
        t_request    dir_rows [N_DIR];
        t_request    rq;
        int unsigned ph;
        int unsigned k;
        logic [LOG_W-1:0] cfg_lg;

        // Directed sequence on the reset value of the minimum block size
        dir_rows = '{
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd0,   1'b1,
              '{7'd0,   5'd0,  bfbp_pkg::ST_UNKNOWN}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'd0,         7'd0,   1'b1,
              '{7'd0,   5'd12, bfbp_pkg::ST_NEW}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'hFFFF_FFFF, 7'd0,   1'b1,
              '{7'd0,   5'd0,  bfbp_pkg::ST_TOO_LARGE}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'h8000_0001, 7'd0,   1'b1,
              '{7'd0,   5'd0,  bfbp_pkg::ST_TOO_LARGE}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'h8000_0000, 7'd0,   1'b1,
              '{7'd1,   5'd31, bfbp_pkg::ST_NEW}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'd1,         7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd0,   1'b1,
              '{7'd0,   5'd12, bfbp_pkg::ST_RELEASED}},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd0,   1'b1,
              '{7'd0,   5'd12, bfbp_pkg::ST_RELEASED}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'd4096,      7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_ACQUIRE, 32'd4097,      7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd1,   1'b0, '0},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd3,   1'b0, '0},
            '{bfbp_pkg::CMD_ACQUIRE, 32'd5000,      7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd127, 1'b1,
              '{7'd127, 5'd0,  bfbp_pkg::ST_UNKNOWN}},
            '{CMD_UNUSED,            32'hFFFF_FFFF, 7'd127, 1'b0, '0},
            '{bfbp_pkg::CMD_ACQUIRE, 32'h4000_0001, 7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_ACQUIRE, 32'h7FFF_FFFF, 7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_CLEAR,   32'd0,         7'd0,   1'b1,
              '{7'd0,   5'd0,  bfbp_pkg::ST_CLEARED}},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd0,   1'b1,
              '{7'd0,   5'd0,  bfbp_pkg::ST_UNKNOWN}},
            '{bfbp_pkg::CMD_ACQUIRE, 32'd2,         7'd0,   1'b0, '0},
            '{bfbp_pkg::CMD_RELEASE, 32'd0,         7'd4,   1'b1,
              '{7'd4,   5'd0,  bfbp_pkg::ST_UNKNOWN}}
        };

        // Hold reset at the start, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < N_DIR; k++)
            issue(dir_rows[k]);

        // Random phases, each with its own idling pattern and block size
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: cfg_lg = '0;
                1: cfg_lg = bfbp_pkg::MAX_LOG2;
                2: cfg_lg = LOG_W'($urandom_range(30, 1));
                default: cfg_lg = bfbp_pkg::MIN_BLOCK_LOG2_RST;
            endcase
            write_min_block(cfg_lg);
            src_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 11 : 0;
            snk_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 11 : 0;
            if (ph == 0) begin
                // Fill the pool to the brim and push past it
                rq    = '0;
                rq.op = bfbp_pkg::CMD_CLEAR;
                issue(rq);
                rq.op = bfbp_pkg::CMD_ACQUIRE;
                repeat (MAX_SLOTS + 3) begin
                    rq.req_size = random_size();
                    issue(rq);
                end
            end
            run_random(N_RAND);
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
